// ===== rtl/ssnf_pkg.sv =====
// Shared types, constants and the segment table for the seven-segment number frame.
package ssnf_pkg;

	localparam int SLOT_MAX = 8;
	localparam int RUN_LEN  = 34;
	localparam int IDX_W    = 6;

	localparam logic [7:0]  CMD_FIXED_ADDR = 8'h44;
	localparam logic [7:0]  CMD_DISPLAY_ON = 8'h8F;
	localparam logic [7:0]  ADDR_BASE      = 8'hC0;
	localparam logic [31:0] RECIP_TEN      = 32'hCCCC_CCCD;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RUN_LEN - 1);
	localparam logic [IDX_W-1:0] FIRST_IDX = '0;

	typedef logic [SLOT_MAX-1:0][7:0] codes_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] value;
		codes_t      codes;
	} stage_t;

	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		unique case (digit)
			4'd0: code = 8'h3f;
			4'd1: code = 8'h06;
			4'd2: code = 8'h5b;
			4'd3: code = 8'h4f;
			4'd4: code = 8'h66;
			4'd5: code = 8'h6d;
			4'd6: code = 8'h7d;
			4'd7: code = 8'h07;
			4'd8: code = 8'h7f;
			4'd9: code = 8'h6f;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/ssnf_ifs.sv =====
// Handshake channels: number beats in, command byte beats out.
interface ssnf_num_if;
	logic        valid;
	logic        ready;
	logic [31:0] number_value;

	modport source (output valid, output number_value, input ready);
	modport sink (input valid, input number_value, output ready);
endinterface

interface ssnf_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] command_byte;
	logic       select_start;
	logic       select_end;
	logic       last_of_run;

	modport source (output valid, output command_byte, output select_start,
		output select_end, output last_of_run, input ready);
	modport sink (input valid, input command_byte, input select_start,
		input select_end, input last_of_run, output ready);
endinterface

// ===== rtl/ssnf_digit_cell.sv =====
// One digit cell: peel the lowest decimal digit, place its segment code, pass the quotient on.
module ssnf_digit_cell
	import ssnf_pkg::*;
#(
	parameter int SLOT = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  stage_t d,
	output stage_t q
);

	logic [63:0] prod;
	logic [28:0] quo;
	logic [31:0] times_ten;
	logic [31:0] rem;
	codes_t      codes_n;
	logic        valid_q;
	logic [31:0] value_q;
	codes_t      codes_q;

	// Divide by ten: multiply by the reciprocal, keep the top bits.
	assign prod      = 64'(d.value) * 64'(RECIP_TEN);
	assign quo       = prod[63:35];
	assign times_ten = {quo, 3'b000} + {2'b00, quo, 1'b0};
	assign rem       = d.value - times_ten;

	always_comb begin
		codes_n       = d.codes;
		codes_n[SLOT] = seg_code(rem[3:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= {3'b000, quo};
			codes_q <= codes_n;
		end
	end

	assign q = '{valid: valid_q, value: value_q, codes: codes_q};

endmodule

// ===== rtl/ssnf_run_ser.sv =====
// Run serializer: hold one frame of codes and step through the 34 command bytes.
module ssnf_run_ser
	import ssnf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  stage_t d,
	output logic take,
	ssnf_cmd_if.source command
);

	logic       busy_q;
	idx_t       idx_q;
	codes_t     codes_q;
	logic       fire;
	logic       at_last;
	idx_t       pair_idx;
	logic [3:0] pos;

	assign fire    = command.valid && command.ready;
	assign at_last = (idx_q == LAST_IDX);
	// Load a new frame when empty or as the closing byte leaves.
	assign take    = d.valid && (!busy_q || (fire && at_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= FIRST_IDX;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= FIRST_IDX;
		end else if (fire) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			codes_q <= d.codes;
		end
	end

	assign pair_idx = idx_q - 1'b1;
	assign pos      = pair_idx[4:1];

	assign command.valid = busy_q;

	always_comb begin
		priority if (idx_q == FIRST_IDX) begin
			command.command_byte = CMD_FIXED_ADDR;
			command.select_start = 1'b1;
			command.select_end   = 1'b1;
			command.last_of_run  = 1'b0;
		end else if (at_last) begin
			command.command_byte = CMD_DISPLAY_ON;
			command.select_start = 1'b1;
			command.select_end   = 1'b1;
			command.last_of_run  = 1'b1;
		end else if (!pair_idx[0]) begin
			command.command_byte = ADDR_BASE | {4'b0000, pos};
			command.select_start = 1'b1;
			command.select_end   = 1'b0;
			command.last_of_run  = 1'b0;
		end else begin
			command.command_byte = pos[0] ? 8'h00 : codes_q[pos[3:1]];
			command.select_start = 1'b0;
			command.select_end   = 1'b1;
			command.last_of_run  = 1'b0;
		end
	end

endmodule

// ===== rtl/seven_segment_number_frame.sv =====
// Top level: number in, 34-byte seven-segment display command run out.
//
// Each number beat on the input channel turns into one run of 34 command byte
// beats: the fixed-address command 0x44, sixteen address/data pairs at
// 0xC0..0xCF (even positions carry segment codes of the low DIGIT_COUNT
// decimal digits, most significant first, leading zeros shown as 0; odd
// positions and unused digit slots carry zero), then 0x8F to switch the
// display on at full brightness. select_start / select_end mark where chip
// select falls before and rises after a byte; last_of_run flags the 0x8F.
// Digits are split by a row of cells, one per digit slot in use (DIGIT_COUNT
// clamped to 1..8), one digit per cell per cycle while the row advances. A
// number passes through the cell registers in turn; with the serializer free,
// it is loaded once it reaches the end of the row, and its first byte is
// offered in the cycle after the load. The output channel moves one byte per
// cycle while ready is high; sustained throughput is one number per run of 34
// bytes, set by that single byte lane. While a run is emitted the cell row
// keeps accepting numbers until a frame waits at its tail, and a waiting frame
// loads as the closing byte is taken, so runs follow each other with no gap.
module seven_segment_number_frame
	import ssnf_pkg::*;
#(
	parameter int DIGIT_COUNT = 8
) (
	input logic clk,
	input logic arst_n,
	ssnf_num_if.sink number,
	ssnf_cmd_if.source command
);

	// Clamp the digit count into the slots the frame has.
	localparam int Slots = (DIGIT_COUNT < 1) ? 1 :
		((DIGIT_COUNT > SLOT_MAX) ? SLOT_MAX : DIGIT_COUNT);

	stage_t chain [Slots+1];
	logic   take;
	logic   advance;

	// Advance the whole row whenever the tail is free or being loaded.
	assign advance      = !chain[Slots].valid || take;
	assign number.ready = advance;

	assign chain[0].valid = number.valid;
	assign chain[0].value = number.number_value;
	assign chain[0].codes = '0;

	// Cell i peels the i-th lowest digit, which lands in the slot counted
	// back from the last used one.
	for (genvar i = 0; i < Slots; i++) begin : g_cell
		ssnf_digit_cell #(
			.SLOT(Slots - 1 - i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	ssnf_run_ser u_ser (
		.clk     (clk),
		.arst_n  (arst_n),
		.d       (chain[Slots]),
		.take    (take),
		.command (command)
	);

endmodule

// ===== rtl/ssnf_checker.sv =====
// Port-level checks on the command run, bound to the top level.
module ssnf_checker
	import ssnf_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] command_byte,
	input logic       select_start,
	input logic       select_end,
	input logic       last_of_run
);

	logic fire;
	assign fire = out_valid && out_ready;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command_byte))
		else $error("stalled command beat changed");

	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_run |->
			command_byte == CMD_DISPLAY_ON && select_start && select_end)
		else $error("closing beat is not a framed display-on command");

	a_open_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_of_run |=>
			!out_valid || (command_byte == CMD_FIXED_ADDR && !last_of_run))
		else $error("run does not open with the fixed-address command");

	a_first_addr: assert property (@(posedge clk) disable iff (!arst_n)
		fire && command_byte == CMD_FIXED_ADDR && select_end |=>
			out_valid && command_byte == ADDR_BASE && select_start && !select_end)
		else $error("first address does not follow the opening command");

endmodule

bind seven_segment_number_frame ssnf_checker u_ssnf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (command.valid),
	.out_ready    (command.ready),
	.command_byte (command.command_byte),
	.select_start (command.select_start),
	.select_end   (command.select_end),
	.last_of_run  (command.last_of_run)
);

// ===== dv/seven_segment_number_frame_test.sv =====
// Testbench for the seven-segment number frame: directed and random numbers, checked per byte beat.
module seven_segment_number_frame_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ssnf_pkg::*;

	localparam int DIGIT_COUNT = 8;
	localparam int HALF_PERIOD = 5;
	// Long receiver hold-off, long enough for the digit row to fill and stall the input.
	localparam int HOLD_CYCLES = 400;
	// Cycles to let pass once every expected byte has come back.
	localparam int SETTLE_CYCLES = DIGIT_COUNT + 40;
	localparam int DRAIN_LIMIT = 20000;
	localparam int REPORT_LIMIT = 10;

	// Segment patterns for the decimal digits 0..9.
	localparam logic [7:0] SEGMENTS [10] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
	};

	typedef struct packed {
		logic [7:0] command_byte;
		logic       select_start;
		logic       select_end;
		logic       last_of_run;
	} frame_beat_t;

	logic clk;
	logic arst_n;

	ssnf_num_if number_ch ();
	ssnf_cmd_if command_ch ();

	seven_segment_number_frame #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.number(number_ch),
		.command(command_ch)
	);

	// Bytes still owed by the block, oldest first.
	frame_beat_t frame_bytes_due [$];
	int unsigned mismatch_count;

	// Idle and stall rates in percent, set per test phase.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	// A test bumps hold_requests; the receiver process then holds ready low on its own count.
	int unsigned hold_requests;
	int unsigned hold_seen;
	int unsigned hold_left;

	initial begin
		clk = 1'b0;
	end

	always #HALF_PERIOD clk = ~clk;

	// Work out the 34-byte run that one number produces and queue it.
	function automatic void predict_frame(input logic [31:0] value);
		logic [7:0]  digit_codes [16];
		logic [31:0] rest;
		int          slots;
		int          i;
		frame_beat_t beat;
		slots = DIGIT_COUNT < 1 ? 1 : (DIGIT_COUNT > SLOT_MAX ? SLOT_MAX : DIGIT_COUNT);
		rest = value;
		for (i = 0; i < 16; i++) begin
			digit_codes[i] = 8'h00;
		end
		// Least significant digit lands in the last used slot; higher digits drop off.
		for (i = slots - 1; i >= 0; i--) begin
			digit_codes[2 * i] = SEGMENTS[rest % 10];
			rest = rest / 10;
		end
		beat = '{CMD_FIXED_ADDR, 1'b1, 1'b1, 1'b0};
		frame_bytes_due.push_back(beat);
		for (i = 0; i < 16; i++) begin
			beat = '{ADDR_BASE + 8'(i), 1'b1, 1'b0, 1'b0};
			frame_bytes_due.push_back(beat);
			beat = '{digit_codes[i], 1'b0, 1'b1, 1'b0};
			frame_bytes_due.push_back(beat);
		end
		beat = '{CMD_DISPLAY_ON, 1'b1, 1'b1, 1'b1};
		frame_bytes_due.push_back(beat);
	endfunction

	// Offer one number; called just after a falling edge, returns just after one.
	// Valid is left high so back-to-back beats never drop it within one step.
	task automatic send_number(input logic [31:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			number_ch.valid <= 1'b0;
			number_ch.number_value <= $urandom;
			@(negedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.number_value <= value;
		do begin
			@(posedge clk);
		end while (!number_ch.ready);
		predict_frame(value);
		@(negedge clk);
	endtask

	// Receiver: drive ready at the falling edge, honoring the long hold-off when asked.
	always @(negedge clk) begin
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			command_ch.ready <= 1'b0;
		end else begin
			command_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check every accepted byte beat against the oldest expectation.
	always @(posedge clk) begin
		frame_beat_t want;
		frame_beat_t got;
		if (arst_n && command_ch.valid && command_ch.ready) begin
			got = '{command_ch.command_byte, command_ch.select_start,
				command_ch.select_end, command_ch.last_of_run};
			if (frame_bytes_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("%0t: unexpected byte %h start %b end %b last %b", $realtime,
						got.command_byte, got.select_start, got.select_end, got.last_of_run);
				end
			end else begin
				want = frame_bytes_due.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("%0t: byte exp %h got %h | start exp %b got %b | end exp %b got %b | last exp %b got %b",
							$realtime, want.command_byte, got.command_byte,
							want.select_start, got.select_start,
							want.select_end, got.select_end,
							want.last_of_run, got.last_of_run);
					end
				end
			end
		end
	end

	// Hit both ends of the range, a spread of digits in each slot, and dropped high digits.
	task automatic test_digit_extremes();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_number(32'd0);
		send_number(32'd1);
		send_number(32'd9);
		send_number(32'd10);
		send_number(32'd12345678);
		send_number(32'd87654321);
		send_number(32'd90123456);
		send_number(32'd78901234);
		send_number(32'd99999999);
		send_number(32'd100000000);
		send_number(32'd1234567890);
		send_number(32'hFFFF_FFFF);
		send_number(32'h8000_0000);
		send_number(32'h5555_5555);
		send_number(32'hAAAA_AAAA);
		send_number(32'd10000001);
	endtask

	// Random numbers under one idle and stall setting; mostly values that exercise digit boundaries.
	task automatic test_random_numbers(input int count, input int unsigned idle_pct,
		input int unsigned stall_pct);
		logic [31:0] value;
		logic [31:0] decade;
		int          digits;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			digits = $urandom_range(9, 1);
			decade = 32'd1;
			repeat (digits) decade = decade * 10;
			case ($urandom_range(3))
				0: value = $urandom;
				// Numbers below a random power of ten; short ones show zeros in the leading slots.
				1: value = $urandom_range(decade - 1);
				// Just around a power of ten.
				2: value = decade - 32'd2 + 32'($urandom_range(3));
				// Usually above eight digits, so the high digits drop off.
				default: value = 32'd100000000 * $urandom_range(42) + $urandom_range(99999999);
			endcase
			send_number(value);
		end
	endtask

	// Stall the receiver for a long stretch while numbers keep coming at full rate.
	task automatic test_backpressure_fill();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests++;
		repeat (14) send_number($urandom);
	endtask

	task automatic wait_for_drain();
		int waited;
		waited = 0;
		while (frame_bytes_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		number_ch.valid = 1'b0;
		number_ch.number_value = '0;
		command_ch.ready = 1'b0;
		mismatch_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests = 0;
		hold_seen = 0;
		hold_left = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_digit_extremes();
		test_random_numbers(50, 0, 0);
		test_random_numbers(50, 45, 0);
		test_random_numbers(50, 0, 45);
		test_backpressure_fill();
		test_random_numbers(50, 11, 11);

		// Stop offering and let the last runs come out.
		number_ch.valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_for_drain();

		// Anything still owed counts as a failure.
		mismatch_count += frame_bytes_due.size();
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ssnf_pkg.sv
rtl/ssnf_ifs.sv
rtl/ssnf_digit_cell.sv
rtl/ssnf_run_ser.sv
rtl/seven_segment_number_frame.sv
rtl/ssnf_checker.sv
dv/seven_segment_number_frame_test.sv
